// ===== hdl/lfe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfe_pkg
// Shared widths, codes and control bundles of the LED fade envelope block.
// ----------------------------------------------------------------------------
package lfe_pkg;

    localparam int COLOR_W    = 8;                    // one color channel
    localparam int LEVEL_W    = 7;                    // brightness in percent
    localparam int CNT_W      = 16;                   // countdown width
    localparam int DELTA_W    = 8;                    // elapsed time per tick
    localparam int DVD_W      = LEVEL_W + CNT_W;      // level times countdown
    localparam int CHAN_W     = COLOR_W + LEVEL_W;    // base times level
    localparam int RECIP_W    = 13;
    localparam int SCALED_W   = CHAN_W + RECIP_W;
    localparam int PCT_SHIFT  = 19;
    // floor(x / 100) == (x * 5243) >> 19 for every x below 2**15
    localparam logic [RECIP_W-1:0] PCT_RECIP = 13'd5243;
    localparam int SAT_W      = SCALED_W - PCT_SHIFT; // quotient bits before clamp
    localparam int NUM_CHAN   = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 7'd100;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BASE_RED   = 3'd0,
        CFG_BASE_GREEN = 3'd1,
        CFG_BASE_BLUE  = 3'd2,
        CFG_MAX_LEVEL  = 3'd3,
        CFG_RISE_TICKS = 3'd4,
        CFG_FALL_TICKS = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_RESTART = 2'd0,
        PH_RISE    = 2'd1,
        PH_FALL    = 2'd2,
        PH_HOLD    = 2'd3
    } phase_t;

    typedef struct packed {
        logic load;       // take the input item, step the countdowns
        logic mul;        // form level times remaining count
        logic div_start;  // launch the divider
        logic scale;      // base times level per channel
        logic recip;      // multiply by the reciprocal of 100
        logic paint;      // update the current color
        logic out_load;   // move the result into the output register
    } lfe_cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   div_done;
        logic   out_free;
    } lfe_status_t;

endpackage : lfe_pkg
`default_nettype wire

// ===== hdl/lfe_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfe_div
    import lfe_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W:0]    trial;
    logic              fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        fits      = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DVD_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract where it fits
            rem_next  = fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_start_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && (step_reg == STEP_W'(DVD_W - 1)))
        else $error("divider did not load its step count");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && divisor != '0) |=> ($past(divisor) == '0) ||
            (rem_reg < $past(divisor)))
        else $error("partial remainder not below divisor");

endmodule : lfe_div
`default_nettype wire

// ===== hdl/lfe_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfe_ctrl
// Sequencer: accept an item, walk the datapath steps, hand off the result.
// ----------------------------------------------------------------------------
module lfe_ctrl
    import lfe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire lfe_status_t status,
    output lfe_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SCALE,
        ST_RECIP,
        ST_PAINT,
        ST_WRITE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                unique case (status.phase)
                    PH_RESTART:       state_next = ST_SCALE;
                    PH_RISE, PH_FALL: state_next = ST_MUL;
                    default:          state_next = ST_WRITE;
                endcase
            end
            ST_MUL:      state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (status.div_done) state_next = ST_SCALE;
            ST_SCALE:    state_next = ST_RECIP;
            ST_RECIP:    state_next = ST_PAINT;
            ST_PAINT:    state_next = ST_WRITE;
            ST_WRITE:    if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign cmd.load      = (state_reg == ST_IDLE) && s_valid;
    assign cmd.mul       = (state_reg == ST_MUL);
    assign cmd.div_start = (state_reg == ST_DIV_GO);
    assign cmd.scale     = (state_reg == ST_SCALE);
    assign cmd.recip     = (state_reg == ST_RECIP);
    assign cmd.paint     = (state_reg == ST_PAINT);
    assign cmd.out_load  = (state_reg == ST_WRITE) && status.out_free;

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside the wait step");

    a_paint_then_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.paint |=> (state_reg == ST_WRITE))
        else $error("painted color not handed off");

    a_load_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_DISPATCH) && !s_ready)
        else $error("accepted item not dispatched");

endmodule : lfe_ctrl
`default_nettype wire

// ===== hdl/lfe_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfe_dpath
// Registers, countdowns, level arithmetic, color scaling and output register.
// ----------------------------------------------------------------------------
module lfe_dpath
    import lfe_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_req_type,
    input  wire logic [DELTA_W-1:0]    s_elapsed,
    input  wire lfe_cmd_t              cmd,
    output lfe_status_t                status,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [COLOR_W-1:0]    m_out_red,
    output logic      [COLOR_W-1:0]    m_out_green,
    output logic      [COLOR_W-1:0]    m_out_blue,
    output logic                       m_fading
);

    // programmed registers
    logic [COLOR_W-1:0] cfg_base_reg [NUM_CHAN];
    logic [LEVEL_W-1:0] cfg_max_reg;
    logic [CNT_W-1:0]   cfg_rise_reg;
    logic [CNT_W-1:0]   cfg_fall_reg;

    // copies latched by a restart
    logic [COLOR_W-1:0] run_base_reg [NUM_CHAN];
    logic [LEVEL_W-1:0] run_max_reg;
    logic [CNT_W-1:0]   run_rise_reg;
    logic [CNT_W-1:0]   run_fall_reg;

    logic [CNT_W-1:0]   rise_left_reg, fall_left_reg;
    logic [COLOR_W-1:0] cur_reg [NUM_CHAN];
    phase_t             phase_reg, phase_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [DVD_W-1:0]   prod_reg;
    logic [CHAN_W-1:0]  chan_reg [NUM_CHAN];
    logic [SCALED_W-1:0] scaled_reg [NUM_CHAN];
    logic               m_valid_reg;

    logic [CNT_W-1:0]   delta_ext;
    logic [CNT_W-1:0]   rise_step, fall_step;
    logic [CNT_W-1:0]   mul_left, div_divisor;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;
    logic               out_free;

    assign delta_ext = {{(CNT_W - DELTA_W){1'b0}}, s_elapsed};
    assign rise_step = (rise_left_reg > delta_ext) ? rise_left_reg - delta_ext : '0;
    assign fall_step = (fall_left_reg > delta_ext) ? fall_left_reg - delta_ext : '0;

    always_comb begin
        if (s_req_type) begin
            phase_next = PH_RESTART;
        end else if (rise_left_reg != '0 && run_rise_reg != '0) begin
            phase_next = PH_RISE;
        end else if (fall_left_reg != '0 && run_fall_reg != '0) begin
            phase_next = PH_FALL;
        end else begin
            phase_next = PH_HOLD;
        end
    end

    assign mul_left    = (phase_reg == PH_RISE) ? rise_left_reg : fall_left_reg;
    assign div_divisor = (phase_reg == PH_RISE) ? run_rise_reg : run_fall_reg;
    assign out_free    = !m_valid_reg || m_ready;

    lfe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHAN; i++) cfg_base_reg[i] <= '0;
            cfg_max_reg  <= MAX_LEVEL_RST;
            cfg_rise_reg <= '0;
            cfg_fall_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_BASE_RED:   cfg_base_reg[0] <= cfg_wr_data[COLOR_W-1:0];
                CFG_BASE_GREEN: cfg_base_reg[1] <= cfg_wr_data[COLOR_W-1:0];
                CFG_BASE_BLUE:  cfg_base_reg[2] <= cfg_wr_data[COLOR_W-1:0];
                CFG_MAX_LEVEL:  cfg_max_reg     <= cfg_wr_data[LEVEL_W-1:0];
                CFG_RISE_TICKS: cfg_rise_reg    <= cfg_wr_data[CNT_W-1:0];
                CFG_FALL_TICKS: cfg_fall_reg    <= cfg_wr_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // envelope state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
                run_base_reg[i] <= '0;
                cur_reg[i]      <= '0;
            end
            run_max_reg   <= MAX_LEVEL_RST;
            run_rise_reg  <= '0;
            run_fall_reg  <= '0;
            rise_left_reg <= '0;
            fall_left_reg <= '0;
            phase_reg     <= PH_HOLD;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                phase_reg <= phase_next;
                unique case (phase_next)
                    PH_RESTART: begin
                        for (int i = 0; i < NUM_CHAN; i++) run_base_reg[i] <= cfg_base_reg[i];
                        run_max_reg   <= cfg_max_reg;
                        run_rise_reg  <= cfg_rise_reg;
                        run_fall_reg  <= cfg_fall_reg;
                        rise_left_reg <= cfg_rise_reg;
                        fall_left_reg <= cfg_fall_reg;
                    end
                    PH_RISE: rise_left_reg <= rise_step;
                    PH_FALL: fall_left_reg <= fall_step;
                    default: ;
                endcase
            end
            if (cmd.paint) begin
                // clamp a quotient that overflows one channel
                for (int i = 0; i < NUM_CHAN; i++) begin
                    cur_reg[i] <= scaled_reg[i][SCALED_W-1] ? {COLOR_W{1'b1}} :
                        scaled_reg[i][PCT_SHIFT +: COLOR_W];
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // arithmetic pipeline, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            // restart: full level at once when there is no rise
            level_reg <= (cfg_rise_reg == '0) ? cfg_max_reg : '0;
        end else if (div_done) begin
            level_reg <= (phase_reg == PH_RISE) ?
                LEVEL_W'(run_max_reg - div_q[LEVEL_W-1:0]) : div_q[LEVEL_W-1:0];
        end
        if (cmd.mul) begin
            prod_reg <= DVD_W'(run_max_reg) * DVD_W'(mul_left);
        end
        for (int i = 0; i < NUM_CHAN; i++) begin
            if (cmd.scale) begin
                chan_reg[i] <= CHAN_W'(run_base_reg[i]) * CHAN_W'(level_reg);
            end
            if (cmd.recip) begin
                scaled_reg[i] <= SCALED_W'(chan_reg[i]) * SCALED_W'(PCT_RECIP);
            end
        end
        if (cmd.out_load) begin
            m_out_red   <= cur_reg[0];
            m_out_green <= cur_reg[1];
            m_out_blue  <= cur_reg[2];
            m_fading    <= (rise_left_reg != '0) || (fall_left_reg != '0);
        end
    end

    // clamp must only trip on the top quotient bit
    if (SAT_W != COLOR_W + 1) begin : g_bad_width
        $error("scaled quotient width does not match the clamp");
    end

    assign status.phase    = phase_reg;
    assign status.div_done = div_done;
    assign status.out_free = out_free;
    assign m_valid         = m_valid_reg;

    a_quotient_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (div_q <= DVD_W'(run_max_reg)))
        else $error("level quotient above peak level");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("output register overwritten");

    a_rise_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        rise_left_reg <= run_rise_reg)
        else $error("rise countdown above rise length");

    a_fall_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fall_left_reg <= run_fall_reg)
        else $error("fall countdown above fall length");

endmodule : lfe_dpath
`default_nettype wire

// ===== hdl/led_fade_envelope_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led_fade_envelope_top
// Linear fade-in / fade-out brightness envelope for one RGB LED.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_req_type, s_elapsed
//  m_        out        m_valid/m_ready    m_out_red/green/blue, m_fading
//  cfg_      in         cfg_wr_en          cfg_addr, cfg_wr_data
//
//  Items: one item at a time. A rise or fall tick runs through the
//  23-step restoring divider (one quotient bit a cycle); a restart skips
//  the divider, and a tick with both countdowns at zero goes straight to
//  the write step.
//  Reset: synchronous, active low; countdowns and colors clear, peak level
//  resets to 100 percent. No clearing pass.
//  Stalls: the result sits in an output register; the next item is accepted
//  while it waits, and the block holds in its write step until it is taken.
//
module led_fade_envelope_top
    import lfe_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    // input items
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_req_type,
    input  wire logic [DELTA_W-1:0]    s_elapsed,
    // result items
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [COLOR_W-1:0]    m_out_red,
    output logic      [COLOR_W-1:0]    m_out_green,
    output logic      [COLOR_W-1:0]    m_out_blue,
    output logic                       m_fading
);

    // sequencer commands and datapath status
    lfe_cmd_t    cmd;
    lfe_status_t status;

    // controller: accept, dispatch by phase, step the arithmetic, hand off
    lfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: registers, countdowns, divider, color scaling, output register
    lfe_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_req_type  (s_req_type),
        .s_elapsed   (s_elapsed),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_fading    (m_fading)
    );

endmodule : led_fade_envelope_top
`default_nettype wire
